// ===== rtl/core/amrf_pkg.sv =====
package amrf_pkg;

	localparam int NSLOT = 17;
	localparam int SLOT_W = $clog2(NSLOT);

	localparam logic [1:0] CFG_BASE = 2'd0;
	localparam logic [1:0] CFG_MODE = 2'd1;
	localparam logic [1:0] CFG_IRQ  = 2'd2;

	localparam logic [9:0] BASE_RST = 10'h220;
	localparam logic [3:0] IRQ_RST  = 4'd5;

	// mixer register addresses
	localparam logic [7:0] MIX_00 = 8'h00;
	localparam logic [7:0] MIX_02 = 8'h02;
	localparam logic [7:0] MIX_06 = 8'h06;
	localparam logic [7:0] MIX_08 = 8'h08;
	localparam logic [7:0] MIX_0C = 8'h0c;
	localparam logic [7:0] MIX_14 = 8'h14;
	localparam logic [7:0] MIX_1C = 8'h1c;
	localparam logic [7:0] MIX_22 = 8'h22;
	localparam logic [7:0] MIX_26 = 8'h26;
	localparam logic [7:0] MIX_28 = 8'h28;
	localparam logic [7:0] MIX_2E = 8'h2e;
	localparam logic [7:0] MIX_30 = 8'h30;
	localparam logic [7:0] MIX_32 = 8'h32;
	localparam logic [7:0] MIX_36 = 8'h36;
	localparam logic [7:0] MIX_38 = 8'h38;
	localparam logic [7:0] MIX_3E = 8'h3e;
	localparam logic [7:0] MIX_40 = 8'h40;
	localparam logic [7:0] MIX_04 = 8'h04;

	localparam logic [7:0] MASK_PAIR = 8'hee;
	localparam logic [7:0] MASK_LOW  = 8'h0e;
	localparam logic [7:0] OFS_20    = 8'h20;
	localparam logic [7:0] OFS_10    = 8'h10;
	localparam logic [7:0] UNLISTED  = 8'h0a;
	localparam logic [7:0] ID_BYTE0  = 8'h16;
	localparam logic [7:0] ID_BYTE1  = 8'h88;
	localparam logic [1:0] MIDI_HI   = 2'b11;

	localparam logic [2:0] CAP_MIC   = 3'd1;
	localparam logic [2:0] CAP_CD    = 3'd2;
	localparam logic [2:0] CAP_LINE  = 3'd3;
	localparam logic [2:0] CAP_MIXER = 3'd4;

	// readable registers, one slot each
	localparam logic [7:0] MIX_ADDR [NSLOT] = '{
		8'h02, 8'h04, 8'h06, 8'h0a, 8'h0c, 8'h0e, 8'h14, 8'h22, 8'h26,
		8'h28, 8'h2e, 8'h30, 8'h32, 8'h36, 8'h38, 8'h3e, 8'h40
	};
	localparam logic [7:0] MIX_PAT [NSLOT] = '{
		8'h00, 8'hee, 8'h00, 8'h00, 8'h00, 8'h00, 8'h88, 8'hee, 8'hee,
		8'hee, 8'h00, 8'h00, 8'h88, 8'h88, 8'h88, 8'h00, 8'h00
	};
	localparam logic [NSLOT-1:0] PAT_HIT = 17'b0_1111_0111_1111_1010;

	localparam logic [SLOT_W-1:0] SLOT_0C = SLOT_W'(4);
	localparam logic [SLOT_W-1:0] SLOT_0E = SLOT_W'(5);

	typedef struct packed {
		logic load_item;
		logic primary;
		logic mirror;
		logic finish;
	} cmd_t;

	function automatic logic [3:0] midi_irq_of(input logic [2:0] mode);
		logic [3:0] r;
		unique case (mode)
			3'd3: r = 4'd11;
			3'd4: r = 4'd9;
			3'd5: r = 4'd5;
			3'd6: r = 4'd7;
			3'd7: r = 4'd10;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/amrf_ifs.sv =====
interface amrf_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic       port_select;
	logic [7:0] write_data;

	modport source(output valid, action, port_select, write_data, input ready);
	modport sink(input valid, action, port_select, write_data, output ready);
endinterface

interface amrf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       stereo_on;
	logic       output_filter_on;
	logic       input_filter_on;
	logic       input_filter_high;
	logic [2:0] capture_source;
	logic [9:0] midi_port_base;
	logic [3:0] midi_port_irq;
	logic       gameport_on;

	modport source(output valid, read_data, stereo_on, output_filter_on, input_filter_on,
		input_filter_high, capture_source, midi_port_base, midi_port_irq, gameport_on,
		input ready);
	modport sink(input valid, read_data, stereo_on, output_filter_on, input_filter_on,
		input_filter_high, capture_source, midi_port_base, midi_port_irq, gameport_on,
		output ready);
endinterface

// ===== rtl/core/audio_mixer_register_file.sv =====
// Mixer register file, reached through an index port and a data port.
// req carries one bus access per item: action (0 read, 1 write),
// port_select (0 index port, 1 data port) and write_data.
// rsp returns one item per access: read_data (zero on writes) and the
// decoded mixer state after the access (filters, stereo, capture source,
// MIDI base and interrupt, joystick enable).
// The response is valid once the response register is loaded. One access is
// in flight at a time; the sequencer takes the item, then does the primary
// register update or read, then the mirror updates, then loads the response
// register, and takes the next item only after it has returned to idle.
// The response register decouples the sides: when rsp stalls, the next item
// is still accepted and worked, and waits in its last step until rsp frees.
// cfg_write/cfg_index/cfg_data set base address (0), ID mode (1) and DSP
// interrupt (2); write them only while idle.
// Reset loads the mixer reset pattern, clears index, ID position, capture
// source and MIDI decode, enables the joystick port and restores config.
module audio_mixer_register_file
	import amrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	amrf_req_if.sink    req,
	amrf_rsp_if.source  rsp,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	cmd_t cmd;

	amrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	amrf_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.action            (req.action),
		.port_select       (req.port_select),
		.write_data        (req.write_data),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.read_data         (rsp.read_data),
		.stereo_on         (rsp.stereo_on),
		.output_filter_on  (rsp.output_filter_on),
		.input_filter_on   (rsp.input_filter_on),
		.input_filter_high (rsp.input_filter_high),
		.capture_source    (rsp.capture_source),
		.midi_port_base    (rsp.midi_port_base),
		.midi_port_irq     (rsp.midi_port_irq),
		.gameport_on       (rsp.gameport_on)
	);

endmodule

// ===== rtl/core/amrf_ctrl.sv =====
module amrf_ctrl
	import amrf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PRIM = 2'd1;
	localparam logic [1:0] ST_MIRR = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.load_item = 1'b0;
		cmd.primary   = 1'b0;
		cmd.mirror    = 1'b0;
		cmd.finish    = 1'b0;
		state_d       = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_PRIM;
				end
			end
			ST_PRIM: begin
				cmd.primary = 1'b1;
				state_d     = ST_MIRR;
			end
			ST_MIRR: begin
				cmd.mirror = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/amrf_dpath.sv =====
module amrf_dpath
	import amrf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       action,
	input  logic       port_select,
	input  logic [7:0] write_data,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	output logic [7:0] read_data,
	output logic       stereo_on,
	output logic       output_filter_on,
	output logic       input_filter_on,
	output logic       input_filter_high,
	output logic [2:0] capture_source,
	output logic [9:0] midi_port_base,
	output logic [3:0] midi_port_irq,
	output logic       gameport_on
);

	logic       act_q;
	logic       sel_q;
	logic [7:0] wd_q;

	logic [9:0] base_q;
	logic       mode_q;
	logic [3:0] irq_q;

	logic [7:0] idx_q;
	logic [1:0] idpos_q;
	logic [2:0] cap_q;
	logic [9:0] mbase_q;
	logic [3:0] mirq_q;
	logic       game_q;
	logic [7:0] rd_q;
	logic [7:0] mreg_q [NSLOT];

	logic       data_wr;
	logic       pat_load;
	logic       wa_en;
	logic [7:0] wa_addr;
	logic [7:0] wa_data;
	logic       wb_en;
	logic [7:0] wb_addr;
	logic [7:0] wb_data;
	logic [7:0] rd_val;
	logic [7:0] reg_val;
	logic [7:0] id_val;

	assign data_wr = act_q && sel_q;

	always_comb begin
		pat_load = 1'b0;
		wa_en    = 1'b0;
		wa_addr  = idx_q;
		wa_data  = wd_q;
		wb_en    = 1'b0;
		wb_addr  = idx_q + OFS_10;
		wb_data  = wd_q;
		if (cmd.primary && data_wr) begin
			if (idx_q == MIX_00)
				pat_load = 1'b1;
			else
				wa_en = 1'b1;
		end
		if (cmd.mirror && data_wr) begin
			unique case (idx_q)
				MIX_02, MIX_06, MIX_08: begin
					wa_en   = 1'b1;
					wa_addr = idx_q + OFS_20;
					wa_data = {wd_q[3:1], 1'b0, wd_q[3:1], 1'b0};
				end
				MIX_14: begin
					wa_en   = 1'b1;
					wa_addr = MIX_04;
					wa_data = wd_q & MASK_PAIR;
				end
				MIX_22, MIX_26, MIX_28, MIX_2E: begin
					wa_en   = 1'b1;
					wa_addr = idx_q - OFS_20;
					wa_data = wd_q & MASK_LOW;
					wb_en   = 1'b1;
				end
				MIX_30, MIX_32, MIX_36, MIX_38, MIX_3E: begin
					wa_en   = 1'b1;
					wa_addr = idx_q - OFS_10;
					wa_data = wd_q & MASK_PAIR;
				end
				default: wa_en = 1'b0;
			endcase
		end
	end

	always_comb begin
		reg_val = UNLISTED;
		for (int k = 0; k < NSLOT; k++) begin
			if (idx_q == MIX_ADDR[k])
				reg_val = mreg_q[k];
		end
		if (idx_q == MIX_00)
			reg_val = MIX_00;
	end

	always_comb begin
		unique case (idpos_q)
			2'd0: id_val = ID_BYTE0;
			2'd1: id_val = ID_BYTE1;
			2'd2: id_val = {6'd0, base_q[9:8]};
			default: id_val = base_q[7:0];
		endcase
	end

	always_comb begin
		if (!sel_q)
			rd_val = idx_q;
		else if (idx_q == MIX_40 && mode_q)
			rd_val = id_val;
		else
			rd_val = reg_val;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q <= action;
			sel_q <= port_select;
			wd_q  <= write_data;
		end
		if (cmd.primary)
			rd_q <= act_q ? 8'd0 : rd_val;
		if (cmd.finish) begin
			read_data         <= rd_q;
			stereo_on         <= mreg_q[SLOT_0E][1];
			output_filter_on  <= !mreg_q[SLOT_0E][5];
			input_filter_on   <= !mreg_q[SLOT_0C][5];
			input_filter_high <= mreg_q[SLOT_0C][3];
			capture_source    <= cap_q;
			midi_port_base    <= mbase_q;
			midi_port_irq     <= mirq_q;
			gameport_on       <= game_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			mode_q <= 1'b0;
			irq_q  <= IRQ_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_BASE: base_q <= cfg_data;
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_IRQ:  irq_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSLOT; k++)
				mreg_q[k] <= MIX_PAT[k];
		end else begin
			for (int k = 0; k < NSLOT; k++) begin
				if (pat_load && PAT_HIT[k])
					mreg_q[k] <= MIX_PAT[k];
				else if (wb_en && wb_addr == MIX_ADDR[k])
					mreg_q[k] <= wb_data;
				else if (wa_en && wa_addr == MIX_ADDR[k])
					mreg_q[k] <= wa_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 8'd0;
			idpos_q <= 2'd0;
			cap_q   <= 3'd0;
			mbase_q <= 10'd0;
			mirq_q  <= 4'd0;
			game_q  <= 1'b1;
		end else if (cmd.primary) begin
			if (act_q && !sel_q) begin
				idx_q <= wd_q;
				if (wd_q == MIX_40)
					idpos_q <= 2'd0;
			end else if (!act_q && sel_q && idx_q == MIX_40 && mode_q) begin
				idpos_q <= idpos_q + 2'd1;
			end else if (data_wr) begin
				unique case (idx_q)
					MIX_0C: begin
						if (wd_q[2:1] == 2'b01)
							cap_q <= CAP_CD;
						else if (wd_q[2:1] == 2'b11)
							cap_q <= CAP_LINE;
						else
							cap_q <= CAP_MIC;
					end
					MIX_1C: begin
						if (wd_q[2:0] == 3'b111)
							cap_q <= CAP_MIXER;
						else if (wd_q[2:0] == 3'b110)
							cap_q <= CAP_LINE;
						else if (wd_q[2:1] == 2'b01)
							cap_q <= CAP_CD;
						else
							cap_q <= CAP_MIC;
					end
					MIX_40: begin
						game_q <= wd_q[1];
						if (wd_q[7:5] == 3'd0) begin
							mbase_q <= 10'd0;
							mirq_q  <= 4'd0;
						end else begin
							mbase_q <= {MIDI_HI, 2'b00, wd_q[4:3], 4'd0};
							mirq_q  <= (wd_q[7:5] == 3'd2) ? irq_q : midi_irq_of(wd_q[7:5]);
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/amrf_checker.sv =====
module amrf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic [9:0] rsp_midi_port_base
);

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 2'd0;
		else if (req_acc && !rsp_acc)
			pend_q <= pend_q + 2'd1;
		else if (rsp_acc && !req_acc)
			pend_q <= pend_q - 2'd1;
	end

	// sequencer stays busy through the primary, mirror and done states after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready ##1 !req_ready ##1 !req_ready)
		else $error("req ready too soon after accept");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("too many items in flight");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an accepted item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
			&& $stable(rsp_midi_port_base))
		else $error("stalled response changed");

endmodule

bind audio_mixer_register_file amrf_checker u_amrf_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_read_data      (rsp.read_data),
	.rsp_midi_port_base (rsp.midi_port_base)
);
